// ===== hdl/gep_pkg.sv =====
// shared types, constants and event tables for the gillespie epidemic step block
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package gep_pkg;

   localparam int NUM_EVENTS         = 18;
   localparam int NUM_SLOTS          = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int EV_W               = 5;
   localparam int SLOT_IDX_W         = 4;
   localparam int MUL_W              = 33;
   localparam int E_W                = 39;
   localparam int DIV_BITS           = E_W + 16;
   localparam int LOG_STEPS          = 32;
   localparam int ITER_W             = 6;
   localparam int NUM_REGS           = 7;
   localparam int CSR_ADDR_W         = 5;

   localparam logic [EV_W-1:0] NO_EVENT_CODE = EV_W'(NUM_EVENTS);
   localparam logic [EV_W-1:0] LAST_EVENT    = EV_W'(NUM_EVENTS - 1);
   localparam logic [16:0]     ONE_Q16       = 17'h10000;
   localparam logic [31:0]     LN2_Q32       = 32'hB17217F7;

   localparam logic [2:0] REG_TRANSMISSION = 3'd0;
   localparam logic [2:0] REG_RECOVERY     = 3'd1;
   localparam logic [2:0] REG_ASYMP_FRAC   = 3'd2;
   localparam logic [2:0] REG_PROGRESSION  = 3'd3;
   localparam logic [2:0] REG_EXCLUSION    = 3'd4;
   localparam logic [2:0] REG_REENTRY      = 3'd5;
   localparam logic [2:0] REG_VACC_SUSC    = 3'd6;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_STEP  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      COEF_BETA,
      COEF_ASY,
      COEF_SYM,
      COEF_GAM,
      COEF_EXCL,
      COEF_REEN,
      COEF_VBETA
   } coef_type;

   typedef struct packed {
      logic [31:0] transmission_rate;
      logic [31:0] recovery_rate;
      logic [16:0] asymptomatic_fraction;
      logic [31:0] progression_rate;
      logic [31:0] exclusion_rate;
      logic [31:0] reentry_rate;
      logic [16:0] vaccinated_susceptibility;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_WRITE,
      OP_READ,
      OP_FRAC_A,
      OP_FRAC_S,
      OP_FRAC_V,
      OP_FRAC_E,
      OP_RATE_MUL,
      OP_RATE_CAP,
      OP_INF_HI,
      OP_INF_LO,
      OP_INF_CMB,
      OP_RATE_ACC,
      OP_NOEV,
      OP_PICK_HI,
      OP_PICK_LO,
      OP_PICK_SUM,
      OP_LOG_NORM,
      OP_LOG_SQ0,
      OP_LOG_SQ,
      OP_LOG_LO,
      OP_LOG_HI,
      OP_LOG_SUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SCAN,
      OP_DEC,
      OP_INC,
      OP_TIME,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [EV_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       total_zero;
      logic       hit;
      logic       rsp_free;
   } status_type;

   // rate coefficient of each event
   function automatic coef_type ev_coef(input logic [EV_W-1:0] idx);
      unique case (idx) inside
         5'd0:                      ev_coef = COEF_BETA;
         5'd1, 5'd7, 5'd14:         ev_coef = COEF_ASY;
         5'd2, 5'd8, 5'd15:         ev_coef = COEF_SYM;
         5'd3, 5'd4, 5'd9, 5'd10,
         5'd16, 5'd17:              ev_coef = COEF_GAM;
         5'd5:                      ev_coef = COEF_EXCL;
         5'd6, 5'd11, 5'd12:        ev_coef = COEF_REEN;
         5'd13:                     ev_coef = COEF_VBETA;
         default:                   ev_coef = COEF_GAM;
      endcase
   endfunction

   // infection events also scale by the infectious count
   function automatic logic ev_has_inf(input logic [EV_W-1:0] idx);
      unique case (idx) inside
         5'd0, 5'd13: ev_has_inf = 1'b1;
         default:     ev_has_inf = 1'b0;
      endcase
   endfunction

   // compartment an event draws from; its count also scales the rate
   function automatic logic [SLOT_IDX_W-1:0] ev_src(input logic [EV_W-1:0] idx);
      unique case (idx) inside
         5'd0, 5'd5:          ev_src = 4'd0;
         5'd1, 5'd2:          ev_src = 4'd1;
         5'd3:                ev_src = 4'd2;
         5'd4:                ev_src = 4'd3;
         5'd6:                ev_src = 4'd5;
         5'd7, 5'd8, 5'd11:   ev_src = 4'd6;
         5'd9, 5'd12:         ev_src = 4'd7;
         5'd10:               ev_src = 4'd8;
         5'd13:               ev_src = 4'd10;
         5'd14, 5'd15:        ev_src = 4'd11;
         5'd16:               ev_src = 4'd12;
         5'd17:               ev_src = 4'd15;
         default:             ev_src = 4'd0;
      endcase
   endfunction

   function automatic logic [SLOT_IDX_W-1:0] ev_into(input logic [EV_W-1:0] idx);
      unique case (idx) inside
         5'd6:                ev_into = 4'd0;
         5'd0, 5'd11:         ev_into = 4'd1;
         5'd1, 5'd12:         ev_into = 4'd2;
         5'd3, 5'd4:          ev_into = 4'd4;
         5'd5:                ev_into = 4'd5;
         5'd7:                ev_into = 4'd7;
         5'd2, 5'd8:          ev_into = 4'd8;
         5'd9, 5'd10:         ev_into = 4'd9;
         5'd13:               ev_into = 4'd11;
         5'd14:               ev_into = 4'd12;
         5'd16, 5'd17:        ev_into = 4'd14;
         5'd15:               ev_into = 4'd15;
         default:             ev_into = 4'd0;
      endcase
   endfunction

endpackage

// ===== hdl/gep_csr.sv =====
// configuration register file behind the apb-style port
// depends on gep_pkg for register indexes and the config struct
`timescale 1ns / 1ps

module gep_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gep_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output gep_pkg::cfg_type                    cfg
);

   gep_pkg::cfg_type cfg_ff;
   gep_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            gep_pkg::REG_TRANSMISSION: cfg_in.transmission_rate = pwdata;
            gep_pkg::REG_RECOVERY:     cfg_in.recovery_rate = pwdata;
            gep_pkg::REG_ASYMP_FRAC:   cfg_in.asymptomatic_fraction = pwdata[16:0];
            gep_pkg::REG_PROGRESSION:  cfg_in.progression_rate = pwdata;
            gep_pkg::REG_EXCLUSION:    cfg_in.exclusion_rate = pwdata;
            gep_pkg::REG_REENTRY:      cfg_in.reentry_rate = pwdata;
            gep_pkg::REG_VACC_SUSC:    cfg_in.vaccinated_susceptibility = pwdata[16:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         gep_pkg::REG_TRANSMISSION: prdata = cfg_ff.transmission_rate;
         gep_pkg::REG_RECOVERY:     prdata = cfg_ff.recovery_rate;
         gep_pkg::REG_ASYMP_FRAC:   prdata = 32'(cfg_ff.asymptomatic_fraction);
         gep_pkg::REG_PROGRESSION:  prdata = cfg_ff.progression_rate;
         gep_pkg::REG_EXCLUSION:    prdata = cfg_ff.exclusion_rate;
         gep_pkg::REG_REENTRY:      prdata = cfg_ff.reentry_rate;
         gep_pkg::REG_VACC_SUSC:    prdata = 32'(cfg_ff.vaccinated_susceptibility);
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/gep_datapath.sv =====
// datapath: compartment counts, time, shared multiplier, rate sums, log, divider
// depends on gep_pkg; driven by commands from gep_ctrl
`timescale 1ns / 1ps

module gep_datapath #(
   parameter int COUNT_BITS = gep_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gep_pkg::cmd_type        cmd,
   output gep_pkg::status_type     status,
   input  gep_pkg::cfg_type        cfg,
   input  logic [1:0]              req_action,
   input  logic [4:0]              req_slot,
   input  logic [63:0]             req_write_value,
   input  logic [31:0]             req_rand_time,
   input  logic [31:0]             req_rand_pick,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [4:0]              rsp_event_fired,
   output logic                    rsp_no_event,
   output logic [63:0]             rsp_step_length,
   output logic [63:0]             rsp_elapsed_time,
   output logic [63:0]             rsp_read_value
);

   localparam int MW     = gep_pkg::MUL_W;
   localparam int INF_W  = COUNT_BITS + 1;
   localparam int NE     = gep_pkg::NUM_EVENTS;
   localparam int NS     = gep_pkg::NUM_SLOTS;
   localparam int DB     = gep_pkg::DIV_BITS;
   localparam int EW     = gep_pkg::E_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // item registers
   logic [1:0]  action_ff;
   logic [4:0]  slot_ff;
   logic [63:0] wv_ff;
   logic [31:0] u1_ff;
   logic [31:0] u2_ff;

   // model state
   logic [COUNT_BITS-1:0] counts_ff [NS];
   logic [63:0]           time_ff;

   // work registers
   logic [31:0]       asy_ff, sym_ff, vbeta_ff;
   logic [INF_W-1:0]  inf_ff;
   logic [2*MW-1:0]   mul_ff, hi_ff;
   logic [63:0]       rate_ff, total_ff, p_ff;
   logic [63:0]       cs_ff [NE];
   logic [NE-1:0]     nz_ff;
   logic [31:0]       y_ff, f_ff;
   logic [4:0]        k_ff;
   logic [EW-1:0]     e_ff;
   logic [DB-1:0]     num_ff, q_ff;
   logic [63:0]       rem_ff;
   logic [4:0]        ev_ff;
   logic              noev_ff;
   logic [63:0]       rd_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [4:0]  rsp_event_ff;
   logic        rsp_no_event_ff;
   logic [63:0] rsp_step_ff, rsp_time_ff, rsp_read_ff;

   // combinational
   logic [16:0]       fa, fv, one_minus_fa;
   logic [31:0]       coef;
   logic [COUNT_BITS-1:0] cnt_src;
   logic [MW-1:0]     mul_a, mul_b;
   logic [4:0]        lead;
   logic [31:0]       x_norm;
   logic [32:0]       sq_w;
   logic [31:0]       y_next;
   logic [37:0]       nl;
   logic [64:0]       trial, diff;
   logic              ge;
   logic [2*MW-1:0]   inf_sum;
   logic              inf_sat;
   logic [64:0]       tot_sum, time_sum;
   logic [63:0]       total_next, dt;
   logic              hit;
   logic [gep_pkg::SLOT_IDX_W-1:0] from_idx, into_idx, wr_idx;

   assign fa = (cfg.asymptomatic_fraction > gep_pkg::ONE_Q16) ?
               gep_pkg::ONE_Q16 : cfg.asymptomatic_fraction;
   assign fv = (cfg.vaccinated_susceptibility > gep_pkg::ONE_Q16) ?
               gep_pkg::ONE_Q16 : cfg.vaccinated_susceptibility;
   assign one_minus_fa = gep_pkg::ONE_Q16 - fa;

   always_comb begin
      unique case (gep_pkg::ev_coef(cmd.idx))
         gep_pkg::COEF_BETA:  coef = cfg.transmission_rate;
         gep_pkg::COEF_ASY:   coef = asy_ff;
         gep_pkg::COEF_SYM:   coef = sym_ff;
         gep_pkg::COEF_GAM:   coef = cfg.recovery_rate;
         gep_pkg::COEF_EXCL:  coef = cfg.exclusion_rate;
         gep_pkg::COEF_REEN:  coef = cfg.reentry_rate;
         gep_pkg::COEF_VBETA: coef = vbeta_ff;
         default:             coef = 32'd0;
      endcase
   end

   assign cnt_src = counts_ff[gep_pkg::ev_src(cmd.idx)];

   // leading one of the time random; zero counts as one
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u1_ff[i]) lead = 5'(i);
      end
   end
   assign x_norm = ((u1_ff == 32'd0) ? 32'd1 : u1_ff) << (5'd31 - lead);

   // one fractional log2 bit per square
   assign sq_w   = mul_ff[63:31];
   assign y_next = sq_w[32] ? sq_w[32:1] : sq_w[31:0];
   assign nl     = {6'd32 - {1'b0, k_ff}, 32'd0} - {6'd0, f_ff};

   assign trial = {rem_ff, num_ff[DB-1]};
   assign diff  = trial - {1'b0, total_ff};
   assign ge    = trial >= {1'b0, total_ff};

   assign inf_sum = {2'b00, hi_ff[31:0], 32'd0} + mul_ff;
   assign inf_sat = (|hi_ff[2*MW-1:32]) || (|inf_sum[2*MW-1:64]);

   assign tot_sum    = {1'b0, total_ff} + {1'b0, rate_ff};
   assign total_next = tot_sum[64] ? '1 : tot_sum[63:0];
   assign dt         = 64'(q_ff);
   assign time_sum   = {1'b0, time_ff} + {1'b0, dt};

   assign hit      = nz_ff[cmd.idx] && (cs_ff[cmd.idx] >= p_ff);
   assign from_idx = gep_pkg::ev_src(ev_ff);
   assign into_idx = gep_pkg::ev_into(ev_ff);
   assign wr_idx   = gep_pkg::SLOT_IDX_W'(slot_ff - 5'd1);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         gep_pkg::OP_FRAC_A: begin
            mul_a = MW'(fa);
            mul_b = MW'(cfg.progression_rate);
         end
         gep_pkg::OP_FRAC_S: begin
            mul_a = MW'(one_minus_fa);
            mul_b = MW'(cfg.progression_rate);
         end
         gep_pkg::OP_FRAC_V: begin
            mul_a = MW'(fv);
            mul_b = MW'(cfg.transmission_rate);
         end
         gep_pkg::OP_RATE_MUL: begin
            mul_a = MW'(coef);
            mul_b = MW'(cnt_src);
         end
         gep_pkg::OP_INF_HI: begin
            mul_a = MW'(rate_ff[63:32]);
            mul_b = MW'(inf_ff);
         end
         gep_pkg::OP_INF_LO: begin
            mul_a = MW'(rate_ff[31:0]);
            mul_b = MW'(inf_ff);
         end
         gep_pkg::OP_PICK_HI: begin
            mul_a = MW'(u2_ff);
            mul_b = MW'(total_ff[63:32]);
         end
         gep_pkg::OP_PICK_LO: begin
            mul_a = MW'(u2_ff);
            mul_b = MW'(total_ff[31:0]);
         end
         gep_pkg::OP_LOG_SQ0: begin
            mul_a = MW'(y_ff);
            mul_b = MW'(y_ff);
         end
         gep_pkg::OP_LOG_SQ: begin
            mul_a = MW'(y_next);
            mul_b = MW'(y_next);
         end
         gep_pkg::OP_LOG_LO: begin
            mul_a = MW'(nl[31:0]);
            mul_b = MW'(gep_pkg::LN2_Q32);
         end
         gep_pkg::OP_LOG_HI: begin
            mul_a = MW'(nl[37:32]);
            mul_b = MW'(gep_pkg::LN2_Q32);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign status.action     = gep_pkg::action_type'(action_ff);
   assign status.total_zero = (total_ff == 64'd0);
   assign status.hit        = hit;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) counts_ff[i] <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            gep_pkg::OP_WRITE: begin
               if (slot_ff == 5'd0) begin
                  time_ff <= wv_ff;
               end else if (slot_ff <= 5'(NS)) begin
                  counts_ff[wr_idx] <= wv_ff[COUNT_BITS-1:0];
               end
            end
            gep_pkg::OP_DEC: begin
               if (counts_ff[from_idx] != '0) counts_ff[from_idx] <= counts_ff[from_idx] - 1'b1;
            end
            gep_pkg::OP_INC: begin
               if (counts_ff[into_idx] != COUNT_MAX) begin
                  counts_ff[into_idx] <= counts_ff[into_idx] + 1'b1;
               end
            end
            gep_pkg::OP_TIME: begin
               time_ff <= time_sum[64] ? '1 : time_sum[63:0];
            end
            default: begin
            end
         endcase
         if (cmd.op == gep_pkg::OP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mul_ff <= (2*MW)'(mul_a) * (2*MW)'(mul_b);
      case (cmd.op)
         gep_pkg::OP_LOAD: begin
            action_ff <= req_action;
            slot_ff   <= req_slot;
            wv_ff     <= req_write_value;
            u1_ff     <= req_rand_time;
            u2_ff     <= req_rand_pick;
            ev_ff     <= gep_pkg::NO_EVENT_CODE;
            noev_ff   <= 1'b0;
            rd_ff     <= '0;
            q_ff      <= '0;
         end
         gep_pkg::OP_READ: begin
            if (slot_ff == 5'd0) begin
               rd_ff <= time_ff;
            end else if (slot_ff <= 5'(NS)) begin
               rd_ff <= 64'(counts_ff[wr_idx]);
            end
         end
         gep_pkg::OP_FRAC_S: asy_ff <= mul_ff[47:16];
         gep_pkg::OP_FRAC_V: sym_ff <= mul_ff[47:16];
         gep_pkg::OP_FRAC_E: begin
            vbeta_ff <= mul_ff[47:16];
            total_ff <= '0;
            inf_ff   <= INF_W'(counts_ff[2]) + INF_W'(counts_ff[12]);
         end
         gep_pkg::OP_RATE_CAP: rate_ff <= mul_ff[63:0];
         gep_pkg::OP_INF_LO:   hi_ff <= mul_ff;
         gep_pkg::OP_INF_CMB:  rate_ff <= inf_sat ? '1 : inf_sum[63:0];
         gep_pkg::OP_RATE_ACC: begin
            total_ff          <= total_next;
            cs_ff[cmd.idx]    <= total_next;
            nz_ff[cmd.idx]    <= (rate_ff != 64'd0);
         end
         gep_pkg::OP_NOEV:     noev_ff <= 1'b1;
         gep_pkg::OP_PICK_LO:  p_ff <= mul_ff[63:0];
         gep_pkg::OP_PICK_SUM: p_ff <= p_ff + 64'(mul_ff[63:32]);
         gep_pkg::OP_LOG_NORM: begin
            y_ff <= x_norm;
            k_ff <= lead;
         end
         gep_pkg::OP_LOG_SQ0:  f_ff <= '0;
         gep_pkg::OP_LOG_SQ:   f_ff <= {f_ff[30:0], sq_w[32]};
         gep_pkg::OP_LOG_HI:   e_ff <= EW'(mul_ff[63:32]);
         gep_pkg::OP_LOG_SUM:  e_ff <= e_ff + EW'(mul_ff[63:0]);
         gep_pkg::OP_DIV_INIT: begin
            num_ff <= {e_ff, 16'd0};
            rem_ff <= '0;
            q_ff   <= '0;
         end
         gep_pkg::OP_DIV_STEP: begin
            rem_ff <= ge ? diff[63:0] : trial[63:0];
            q_ff   <= {q_ff[DB-2:0], ge};
            num_ff <= {num_ff[DB-2:0], 1'b0};
         end
         gep_pkg::OP_SCAN: begin
            if (hit) ev_ff <= cmd.idx;
         end
         gep_pkg::OP_RESULT: begin
            rsp_event_ff    <= ev_ff;
            rsp_no_event_ff <= noev_ff;
            rsp_step_ff     <= dt;
            rsp_time_ff     <= time_ff;
            rsp_read_ff     <= rd_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_fired  = rsp_event_ff;
   assign rsp_no_event     = rsp_no_event_ff;
   assign rsp_step_length  = rsp_step_ff;
   assign rsp_elapsed_time = rsp_time_ff;
   assign rsp_read_value   = rsp_read_ff;

   a_norm_msb: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gep_pkg::OP_LOG_NORM) |=> y_ff[31])
      else $error("log operand not normalized");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gep_pkg::OP_DIV_STEP) |=> (rem_ff < total_ff))
      else $error("divider remainder not below divisor");

   a_noev_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_no_event_ff) |-> (rsp_event_ff == gep_pkg::NO_EVENT_CODE))
      else $error("event reported with zero total rate");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gep_pkg::OP_RESULT) |=> rsp_valid_ff)
      else $error("result load did not raise valid");

endmodule

// ===== hdl/gep_ctrl.sv =====
// controller: sequences one request through the datapath by command codes
// depends on gep_pkg for the command and status structs and event tables
`timescale 1ns / 1ps

module gep_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gep_pkg::status_type  status,
   output gep_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_WRITE, S_READ,
      S_FRAC_A, S_FRAC_S, S_FRAC_V, S_FRAC_E,
      S_RATE_MUL, S_RATE_CAP, S_INF_HI, S_INF_LO, S_INF_CMB, S_RATE_ACC,
      S_CHECK, S_NOEV, S_PICK_HI, S_PICK_LO, S_PICK_SUM,
      S_LOG_NORM, S_LOG_SQ0, S_LOG_SQ, S_LOG_LO, S_LOG_HI, S_LOG_SUM,
      S_DIV_INIT, S_DIV, S_SCAN, S_DEC, S_INC, S_TIME, S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [gep_pkg::EV_W-1:0]        idx_ff, idx_in;
   logic [gep_pkg::ITER_W-1:0]      iter_ff, iter_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      iter_in   = iter_ff;
      cmd.op    = gep_pkg::OP_NONE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = gep_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.action)
               gep_pkg::ACT_WRITE: state_in = S_WRITE;
               gep_pkg::ACT_READ:  state_in = S_READ;
               gep_pkg::ACT_STEP:  state_in = S_FRAC_A;
               default:            state_in = S_DONE;
            endcase
         end
         S_WRITE: begin
            cmd.op   = gep_pkg::OP_WRITE;
            state_in = S_DONE;
         end
         S_READ: begin
            cmd.op   = gep_pkg::OP_READ;
            state_in = S_DONE;
         end
         S_FRAC_A: begin
            cmd.op   = gep_pkg::OP_FRAC_A;
            state_in = S_FRAC_S;
         end
         S_FRAC_S: begin
            cmd.op   = gep_pkg::OP_FRAC_S;
            state_in = S_FRAC_V;
         end
         S_FRAC_V: begin
            cmd.op   = gep_pkg::OP_FRAC_V;
            state_in = S_FRAC_E;
         end
         S_FRAC_E: begin
            cmd.op   = gep_pkg::OP_FRAC_E;
            idx_in   = '0;
            state_in = S_RATE_MUL;
         end
         S_RATE_MUL: begin
            cmd.op   = gep_pkg::OP_RATE_MUL;
            state_in = S_RATE_CAP;
         end
         S_RATE_CAP: begin
            cmd.op   = gep_pkg::OP_RATE_CAP;
            state_in = gep_pkg::ev_has_inf(idx_ff) ? S_INF_HI : S_RATE_ACC;
         end
         S_INF_HI: begin
            cmd.op   = gep_pkg::OP_INF_HI;
            state_in = S_INF_LO;
         end
         S_INF_LO: begin
            cmd.op   = gep_pkg::OP_INF_LO;
            state_in = S_INF_CMB;
         end
         S_INF_CMB: begin
            cmd.op   = gep_pkg::OP_INF_CMB;
            state_in = S_RATE_ACC;
         end
         S_RATE_ACC: begin
            cmd.op = gep_pkg::OP_RATE_ACC;
            if (idx_ff == gep_pkg::LAST_EVENT) begin
               state_in = S_CHECK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RATE_MUL;
            end
         end
         S_CHECK: begin
            state_in = status.total_zero ? S_NOEV : S_PICK_HI;
         end
         S_NOEV: begin
            cmd.op   = gep_pkg::OP_NOEV;
            state_in = S_DONE;
         end
         S_PICK_HI: begin
            cmd.op   = gep_pkg::OP_PICK_HI;
            state_in = S_PICK_LO;
         end
         S_PICK_LO: begin
            cmd.op   = gep_pkg::OP_PICK_LO;
            state_in = S_PICK_SUM;
         end
         S_PICK_SUM: begin
            cmd.op   = gep_pkg::OP_PICK_SUM;
            state_in = S_LOG_NORM;
         end
         S_LOG_NORM: begin
            cmd.op   = gep_pkg::OP_LOG_NORM;
            state_in = S_LOG_SQ0;
         end
         S_LOG_SQ0: begin
            cmd.op   = gep_pkg::OP_LOG_SQ0;
            iter_in  = '0;
            state_in = S_LOG_SQ;
         end
         S_LOG_SQ: begin
            cmd.op  = gep_pkg::OP_LOG_SQ;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == gep_pkg::ITER_W'(gep_pkg::LOG_STEPS - 1)) state_in = S_LOG_LO;
         end
         S_LOG_LO: begin
            cmd.op   = gep_pkg::OP_LOG_LO;
            state_in = S_LOG_HI;
         end
         S_LOG_HI: begin
            cmd.op   = gep_pkg::OP_LOG_HI;
            state_in = S_LOG_SUM;
         end
         S_LOG_SUM: begin
            cmd.op   = gep_pkg::OP_LOG_SUM;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = gep_pkg::OP_DIV_INIT;
            iter_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op  = gep_pkg::OP_DIV_STEP;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == gep_pkg::ITER_W'(gep_pkg::DIV_BITS - 1)) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = gep_pkg::OP_SCAN;
            if (status.hit) begin
               state_in = S_DEC;
            end else if (idx_ff == gep_pkg::LAST_EVENT) begin
               state_in = S_TIME;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DEC: begin
            cmd.op   = gep_pkg::OP_DEC;
            state_in = S_INC;
         end
         S_INC: begin
            cmd.op   = gep_pkg::OP_INC;
            state_in = S_TIME;
         end
         S_TIME: begin
            cmd.op   = gep_pkg::OP_TIME;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the result register to free up
            if (status.rsp_free) begin
               cmd.op   = gep_pkg::OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ===== hdl/gillespie_epidemic_step.sv =====
// top level of the gillespie direct-method epidemic step block
// depends on gep_pkg, gep_csr, gep_ctrl and gep_datapath
`timescale 1ns / 1ps

// One request is taken at a time; a new request is accepted while the previous
// result still waits in the output register. Write, read and no-op requests go
// straight from decode to the result. An event step decodes the request, derives
// the split rates, forms each event rate (with two more products for the two
// infection events) through the single shared 33x33 multiplier, tests the total,
// forms the pick threshold, runs the 32-step squaring log2 on the same
// multiplier, runs the bit-serial restoring divider that forms the waiting time,
// scans for the event, applies the moves, advances time and loads the result.
// A zero total rate ends the step after the rate pass. Loading the result waits
// while the previous result still waits in the output register. There is no
// clearing pass after reset.

module gillespie_epidemic_step #(
   parameter int COUNT_BITS = gep_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [4:0]                      req_slot,
   input  logic [63:0]                     req_write_value,
   input  logic [31:0]                     req_rand_time,
   input  logic [31:0]                     req_rand_pick,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [4:0]                      rsp_event_fired,
   output logic                            rsp_no_event,
   output logic [63:0]                     rsp_step_length,
   output logic [63:0]                     rsp_elapsed_time,
   output logic [63:0]                     rsp_read_value,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gep_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   gep_pkg::cfg_type    cfg;
   gep_pkg::cmd_type    cmd;
   gep_pkg::status_type status;

   gep_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gep_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_write_value  (req_write_value),
      .req_rand_time    (req_rand_time),
      .req_rand_pick    (req_rand_pick),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_event_fired  (rsp_event_fired),
      .rsp_no_event     (rsp_no_event),
      .rsp_step_length  (rsp_step_length),
      .rsp_elapsed_time (rsp_elapsed_time),
      .rsp_read_value   (rsp_read_value)
   );

endmodule
